>>> sv/dcq_pkg.sv
// Shared types and constants of the circular deque with compare-on-pop.
`default_nettype none

package dcq_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_LEFT  = 2'd0,
    MODE_PUSH_RIGHT = 2'd1,
    MODE_POP_LEFT   = 2'd2,
    MODE_POP_RIGHT  = 2'd3
  } dcq_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_MISMATCH = 2'd3
  } dcq_status_t;

endpackage

`default_nettype wire

>>> sv/dcq_if.sv
// Request and response channel interfaces of the circular deque.
`default_nettype none

interface dcq_req_if;
  import dcq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dcq_rsp_if;
  import dcq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] end_value;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, output status, output end_value, output count, input ready);
  modport sink   (input valid, input status, input end_value, input count, output ready);
endinterface

`default_nettype wire

>>> sv/circular_deque_compare_pop.sv
// Top level of the circular deque with compare-on-pop, backed by one RAM.
//
//  Channel  Role     Payload                                  Handshake
//  -------  -------  ---------------------------------------  ------------------
//  req      sink     mode[1:0], value[31:0] signed            valid/ready
//  rsp      source   status[1:0], end_value[31:0], count[4:0] valid/ready
//
// For every item, the RAM read of the end slot is launched in the accept
// cycle; then, in the execute state, the read data is compared and the
// indices, the count and the RAM write are committed. One item is in
// work at a time. The response sits in an output register, so a new item is
// accepted while an earlier result still waits; an item only holds in the
// execute state while that register is occupied and not drained. Reset clears
// the indices, the count and control state at once; the RAM needs no clearing.
`default_nettype none

module circular_deque_compare_pop #(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  dcq_req_if.sink  req,
  dcq_rsp_if.source rsp
);
  import dcq_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Index stepping wraps modulo DEPTH, which need not be a power of two.
  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    r = (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    return r;
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    r = (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
    return r;
  endfunction

  state_t                    state;
  dcq_mode_t                 cmd_mode;
  logic signed [VALUE_W-1:0] cmd_value;
  logic [AW-1:0]             left_idx;
  logic [AW-1:0]             right_idx;
  logic [OCC_W-1:0]          occ;

  logic                      rsp_valid;
  dcq_status_t               rsp_status;
  logic signed [VALUE_W-1:0] rsp_end_value;
  logic [COUNT_W-1:0]        rsp_count;

  // RAM port signals.
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [VALUE_W-1:0]        rd_data;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;

  // Commit datapath.
  logic                      commit;
  logic                      is_push;
  logic                      is_full;
  logic                      is_empty;
  dcq_status_t               status_next;
  logic signed [VALUE_W-1:0] end_value_next;
  logic [AW-1:0]             left_idx_next;
  logic [AW-1:0]             right_idx_next;
  logic [OCC_W-1:0]          occ_next;
  logic [31:0]               occ_wide;

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.end_value = rsp_end_value;
  assign rsp.count     = rsp_count;

  // The end slot is read at accept time. The indices only move in the commit
  // cycle, so the address taken here is the one the commit will use. A write
  // happens only in the commit cycle and a read only in the accept cycle, so
  // the two never touch the RAM in the same cycle and no forwarding is needed.
  assign rd_en   = req.valid && req.ready;
  assign rd_addr = (dcq_mode_t'(req.mode) == MODE_POP_LEFT) ? left_idx : right_idx;

  assign commit   = (state == S_EXEC) && (!rsp_valid || rsp.ready);
  assign is_push  = (cmd_mode == MODE_PUSH_LEFT) || (cmd_mode == MODE_PUSH_RIGHT);
  assign is_full  = (occ == OCC_W'(DEPTH));
  assign is_empty = (occ == '0);

  always_comb begin
    status_next    = ST_DONE;
    end_value_next = '0;
    left_idx_next  = left_idx;
    right_idx_next = right_idx;
    occ_next       = occ;
    wr_en          = 1'b0;
    wr_addr        = left_idx;

    unique case (cmd_mode)
      MODE_PUSH_LEFT, MODE_PUSH_RIGHT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          wr_en    = commit;
          occ_next = occ + 1'b1;
          if (is_empty) begin
            // The first element occupies the left slot and both ends name it.
            right_idx_next = left_idx;
            wr_addr        = left_idx;
          end else if (cmd_mode == MODE_PUSH_LEFT) begin
            left_idx_next = step_down(left_idx);
            wr_addr       = left_idx_next;
          end else begin
            right_idx_next = step_up(right_idx);
            wr_addr        = right_idx_next;
          end
        end
      end
      MODE_POP_LEFT, MODE_POP_RIGHT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          end_value_next = rd_data;
          if (rd_data != cmd_value) begin
            status_next = ST_MISMATCH;
          end else begin
            occ_next = occ - 1'b1;
            if (cmd_mode == MODE_POP_LEFT) begin
              left_idx_next = step_up(left_idx);
            end else begin
              right_idx_next = step_down(right_idx);
            end
          end
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // The reported count keeps the low bits of the occupancy.
  assign occ_wide = 32'(occ_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      left_idx  <= '0;
      right_idx <= '0;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A commit refills the output register in the same cycle it drains.
      if (rsp_valid && rsp.ready && !commit) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (rd_en) begin
            cmd_mode  <= dcq_mode_t'(req.mode);
            cmd_value <= req.value;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            left_idx      <= left_idx_next;
            right_idx     <= right_idx_next;
            occ           <= occ_next;
            rsp_valid     <= 1'b1;
            rsp_status    <= status_next;
            rsp_end_value <= end_value_next;
            rsp_count     <= occ_wide[COUNT_W-1:0];
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dcq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (cmd_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // The occupancy never exceeds the store's depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  // A single element is named by both ends.
  a_single_ends: assert property (@(posedge clk) disable iff (rst)
    (occ == OCC_W'(1)) |-> (left_idx == right_idx))
    else $error("single element with diverging ends");

  // The RAM is never written and read in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("RAM read and write overlap");

  // A successful pop lowers the occupancy by exactly one.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (commit && !is_push && (status_next == ST_DONE)) |=> (occ == $past(occ) - 1'b1))
    else $error("pop did not lower the occupancy by one");

endmodule

`default_nettype wire

>>> sv/dcq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module dcq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> test/circular_deque_compare_pop_test.sv
// Self-checking testbench for the circular deque with compare-on-pop.
module circular_deque_compare_pop_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dcq_pkg::*;

  // The deque under test is built with its default depth of sixteen slots.
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned RESET_CYCLES = 12;
  // The random part sends this many items, and the last CALM_ITEMS of them
  // go out with no idling on either side.
  localparam int unsigned RANDOM_ITEMS = 1325;
  localparam int unsigned CALM_ITEMS   = 200;
  // Even with the longest idle burst on the sending side and the longest
  // stall on the receiving side for every item, a run stays well under
  // the limit below.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // A result is registered once its item has been executed, so a short
  // settle at the end is enough to catch any stray result.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    dcq_status_t               status;
    logic [VALUE_W-1:0]        end_value;
    logic [COUNT_W-1:0]        count;
  } deque_result_t;

  // One row of the directed table. Where typed is set, the expected result
  // is the one written in the row; otherwise the predictor supplies it.
  typedef struct {
    dcq_mode_t          mode;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    deque_result_t      want;
  } deque_row_t;

  localparam deque_result_t NO_RESULT = '{ST_DONE, 32'h0, 5'd0};

  // The directed part. It starts by popping an empty deque from both ends,
  // then pushes into an empty deque at either end, checks a mismatching and
  // a matching pop of a single entry, fills all sixteen slots with
  // alternating left and right pushes, the left end wrapping below slot
  // zero, bounces pushes off the full deque, and ends with matching and
  // mismatching pops that start from the full deque.
  deque_row_t directed_ops [26] = '{
    '{MODE_POP_LEFT,   32'h0000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 5'd0}},
    '{MODE_POP_RIGHT,  32'h8000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 5'd0}},
    '{MODE_PUSH_LEFT,  32'h7FFF_FFFF, 1'b1, '{ST_DONE,     32'h0000_0000, 5'd1}},
    '{MODE_POP_RIGHT,  32'h8000_0000, 1'b1, '{ST_MISMATCH, 32'h7FFF_FFFF, 5'd1}},
    '{MODE_POP_LEFT,   32'h7FFF_FFFF, 1'b1, '{ST_DONE,     32'h7FFF_FFFF, 5'd0}},
    '{MODE_PUSH_RIGHT, 32'h8000_0000, 1'b1, '{ST_DONE,     32'h0000_0000, 5'd1}},
    '{MODE_PUSH_LEFT,  32'hFFFF_FFFF, 1'b0, NO_RESULT},
    '{MODE_PUSH_RIGHT, 32'h0000_0000, 1'b0, NO_RESULT},
    '{MODE_PUSH_LEFT,  32'h0000_0001, 1'b0, NO_RESULT},
    '{MODE_PUSH_RIGHT, 32'hAAAA_AAAA, 1'b0, NO_RESULT},
    '{MODE_PUSH_LEFT,  32'h5555_5555, 1'b0, NO_RESULT},
    '{MODE_PUSH_RIGHT, 32'h1234_5678, 1'b0, NO_RESULT},
    '{MODE_PUSH_LEFT,  32'hDEAD_BEEF, 1'b0, NO_RESULT},
    '{MODE_PUSH_RIGHT, 32'h0F0F_0F0F, 1'b0, NO_RESULT},
    '{MODE_PUSH_LEFT,  32'hF0F0_F0F0, 1'b0, NO_RESULT},
    '{MODE_PUSH_RIGHT, 32'h7FFF_FFFE, 1'b0, NO_RESULT},
    '{MODE_PUSH_LEFT,  32'h8000_0001, 1'b0, NO_RESULT},
    '{MODE_PUSH_RIGHT, 32'hC3C3_C3C3, 1'b0, NO_RESULT},
    '{MODE_PUSH_LEFT,  32'h3C3C_3C3C, 1'b0, NO_RESULT},
    '{MODE_PUSH_RIGHT, 32'h0000_FFFF, 1'b0, NO_RESULT},
    '{MODE_PUSH_LEFT,  32'hFFFF_0000, 1'b0, NO_RESULT},
    '{MODE_PUSH_RIGHT, 32'h1111_1111, 1'b1, '{ST_FULL,     32'h0000_0000, 5'd16}},
    '{MODE_PUSH_LEFT,  32'h2222_2222, 1'b1, '{ST_FULL,     32'h0000_0000, 5'd16}},
    '{MODE_POP_LEFT,   32'hFFFF_0000, 1'b1, '{ST_DONE,     32'hFFFF_0000, 5'd15}},
    '{MODE_POP_RIGHT,  32'h0000_0000, 1'b1, '{ST_MISMATCH, 32'h0000_FFFF, 5'd15}},
    '{MODE_POP_RIGHT,  32'h0000_FFFF, 1'b1, '{ST_DONE,     32'h0000_FFFF, 5'd14}}
  };

  logic clk;
  logic rst;

  dcq_req_if req_ch ();
  dcq_rsp_if rsp_ch ();

  circular_deque_compare_pop #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // The predictor's own copy of the deque: the slot store, the two end
  // pointers and the number of entries held. The pointers are exactly as
  // wide as the slot index, so stepping them wraps modulo the depth.
  logic [VALUE_W-1:0] deque_store [DEPTH];
  logic [IDX_W-1:0]   left_end;
  logic [IDX_W-1:0]   right_end;
  logic [COUNT_W-1:0] held;

  // Results still owed by the block, oldest first.
  deque_result_t      owed_results [$];

  int unsigned        failures;
  int unsigned        cycle_count;
  int unsigned        ready_hold;
  bit                 calm_phase;

  // Clock: 1 ns high, 1 ns low.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Applies one item to the predictor's deque and returns the result the
  // block must give for it. A push into an empty deque lands on the slot
  // the left end names and pulls the right end onto it, so both ends agree.
  // A pop compares the whole 32-bit value with the end element and only
  // removes it when they are equal; on a mismatch the element is still
  // reported but the deque stays as it was.
  function automatic deque_result_t apply_deque_op(input dcq_mode_t mode,
                                                   input logic [VALUE_W-1:0] value);
    deque_result_t res;
    res.status    = ST_DONE;
    res.end_value = '0;
    if (mode == MODE_PUSH_LEFT || mode == MODE_PUSH_RIGHT) begin
      if (held == COUNT_W'(DEPTH)) begin
        res.status = ST_FULL;
      end else begin
        if (held == 0) begin
          right_end = left_end;
          deque_store[left_end] = value;
        end else if (mode == MODE_PUSH_LEFT) begin
          left_end = left_end - 1'b1;
          deque_store[left_end] = value;
        end else begin
          right_end = right_end + 1'b1;
          deque_store[right_end] = value;
        end
        held = held + 1'b1;
      end
    end else if (held == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.end_value = (mode == MODE_POP_LEFT) ? deque_store[left_end]
                                              : deque_store[right_end];
      if (res.end_value != value) begin
        res.status = ST_MISMATCH;
      end else begin
        if (mode == MODE_POP_LEFT) begin
          left_end = left_end + 1'b1;
        end else begin
          right_end = right_end - 1'b1;
        end
        held = held - 1'b1;
      end
    end
    res.count = held;
    return res;
  endfunction

  // Offers one item and holds it until the block takes it. Every call
  // starts right after a rising edge. The expectation is recorded at the
  // edge that accepts the item, so the predictor's state is current when
  // the next item is chosen.
  task automatic offer_item(input dcq_mode_t mode, input logic [VALUE_W-1:0] value,
                            input bit typed, input deque_result_t want);
    deque_result_t predicted;
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.value <= value;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    predicted = apply_deque_op(mode, value);
    owed_results.push_back(typed ? want : predicted);
  endtask

  // Now and then the sender goes quiet for a random burst of idle cycles.
  // While valid is low the payload wanders, which the block must ignore.
  task automatic sender_gap();
    if (!calm_phase && $urandom_range(7) == 0) begin
      req_ch.valid <= 1'b0;
      req_ch.mode  <= MODE_W'($urandom_range(3));
      req_ch.value <= $urandom;
      repeat ($urandom_range(6, 1)) begin
        @(posedge clk);
      end
    end
  endtask

  // Stops sending and waits until every owed result has come back.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Picks a random item. Pops mostly name the value really held at that
  // end, so they get past the compare and drain the deque; the rest carry
  // a value with one bit flipped or a fully random one. Pushed values are
  // mostly random words, with a share of the extremes and of tiny values so
  // that equal neighbors turn up. The push share sets whether the deque
  // drifts toward full or toward empty.
  task automatic pick_item(input int unsigned push_pct, output dcq_mode_t mode,
                           output logic [VALUE_W-1:0] value);
    int unsigned        roll;
    logic [VALUE_W-1:0] held_word;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      mode = ($urandom_range(1) == 0) ? MODE_PUSH_LEFT : MODE_PUSH_RIGHT;
      roll = $urandom_range(99);
      case (roll % 10)
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'hFFFF_FFFF;
        3:       value = VALUE_W'($urandom_range(3));
        default: value = $urandom;
      endcase
    end else begin
      mode = ($urandom_range(1) == 0) ? MODE_POP_LEFT : MODE_POP_RIGHT;
      held_word = '0;
      if (held != 0) begin
        held_word = (mode == MODE_POP_LEFT) ? deque_store[left_end]
                                            : deque_store[right_end];
      end
      roll = $urandom_range(99);
      if (roll < 75) begin
        value = held_word;
      end else if (roll < 88) begin
        value = held_word ^ (32'h1 << $urandom_range(VALUE_W - 1));
      end else begin
        value = $urandom;
      end
    end
  endtask

  // The receiving side stalls in random bursts and is always ready during
  // the calm stretch at the end of the run.
  always @(posedge clk) begin
    if (calm_phase) begin
      rsp_ch.ready <= 1'b1;
    end else if (ready_hold != 0) begin
      rsp_ch.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else if ($urandom_range(7) == 0) begin
      rsp_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(5);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Every result taken is checked against the oldest owed one, field by
  // field. Values are sampled at the rising edge, before any update from
  // that edge lands.
  always @(posedge clk) begin
    deque_result_t owed;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (owed_results.size() == 0) begin
        failures = failures + 1;
        if (failures <= MAX_REPORTS) begin
          $display("unexpected result: status %0d end_value %h count %0d",
                   rsp_ch.status, rsp_ch.end_value, rsp_ch.count);
        end
      end else begin
        owed = owed_results.pop_front();
        if (rsp_ch.status !== owed.status || rsp_ch.end_value !== owed.end_value ||
            rsp_ch.count !== owed.count) begin
          failures = failures + 1;
          if (failures <= MAX_REPORTS) begin
            $display("wrong result: expected status %0d end_value %h count %0d, got status %0d end_value %h count %0d",
                     owed.status, owed.end_value, owed.count,
                     rsp_ch.status, rsp_ch.end_value, rsp_ch.count);
          end
        end
      end
    end
  end

  // A run that never settles ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circular_deque_compare_pop: mismatch");
      $finish;
    end
  end

  initial begin
    dcq_mode_t          mode;
    logic [VALUE_W-1:0] value;
    int unsigned        push_pct;
    failures     = 0;
    cycle_count  = 0;
    ready_hold   = 0;
    calm_phase   = 1'b0;
    left_end     = '0;
    right_end    = '0;
    held         = '0;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_PUSH_LEFT;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;

    // Synchronous reset, held at the start of the run and never raised again.
    repeat (RESET_CYCLES) begin
      @(posedge clk);
    end
    rst <= 1'b0;

    foreach (directed_ops[i]) begin
      offer_item(directed_ops[i].mode, directed_ops[i].value,
                 directed_ops[i].typed, directed_ops[i].want);
      sender_gap();
    end

    // Let the block drain completely before the random part begins.
    wait_for_results();

    // The random part moves through stretches of forty items that lean
    // toward pushing, toward popping or neither, so the deque fills to the top
    // and empties out many times, crossing the wrap point of both ends.
    push_pct = 50;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(4))
          0:       push_pct = 85;
          1:       push_pct = 15;
          2:       push_pct = 65;
          3:       push_pct = 35;
          default: push_pct = 50;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) begin
        wait_for_results();
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) begin
        calm_phase <= 1'b1;
      end
      pick_item(push_pct, mode, value);
      offer_item(mode, value, 1'b0, NO_RESULT);
      sender_gap();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) begin
      @(posedge clk);
    end

    if (failures == 0) begin
      $display("circular_deque_compare_pop: match");
    end else begin
      $display("circular_deque_compare_pop: mismatch");
    end
    $finish;
  end

endmodule
